// File: design/hbpg_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hbpg_pkg
// Shared widths, hash constants, default parameters and the pipeline advance
// bundle of the hashed block pattern generator.
// -----------------------------------------------------------------------------
package hbpg_pkg;

   localparam int BYTE_INDEX_W = 18;
   localparam int PAYLOAD_W    = 8;
   localparam int SEED_W       = 32;
   localparam int NIBBLE_W     = 4;
   localparam int LANES        = 2;
   localparam int PIX_W        = BYTE_INDEX_W + $clog2(LANES);
   localparam int LANE_STAGES  = 13;

   localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

   localparam logic [31:0] HASH_SEED = 32'd2654435761;
   localparam logic [31:0] HASH_BX   = 32'd73856093;
   localparam logic [31:0] HASH_BY   = 32'd19349663;
   localparam logic [31:0] FIN_M1    = 32'h7feb352d;
   localparam logic [31:0] FIN_M2    = 32'h846ca68b;
   localparam int          FIN_S1    = 16;
   localparam int          FIN_S2    = 15;
   localparam int          FIN_S3    = 16;

   localparam int DEF_IMG_WIDTH    = 800;
   localparam int DEF_IMG_HEIGHT   = 480;
   localparam int DEF_BLOCK_SIZE   = 40;
   localparam int DEF_PALETTE_SIZE = 7;
   localparam int DEF_BORDER_WIDTH = 4;

   // Per-stage load strobes of the lanes plus the output register strobe.
   typedef struct packed {
      logic [LANE_STAGES-1:0] load;
      logic                   out_load;
   } hbpg_adv_type;

endpackage

// File: design/hbpg_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hbpg_ctrl
// Valid tracking and flow control for the lane pipeline and output register.
// -----------------------------------------------------------------------------
module hbpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hbpg_pkg::hbpg_adv_type  adv
);
   import hbpg_pkg::*;

   logic [LANE_STAGES-1:0] valid_ff;
   logic                   out_valid_ff;
   logic [LANE_STAGES-1:0] ready;
   logic                   out_ready;

   assign out_ready = !(out_valid_ff && rsp_stall);

   // A stage may load unless it and every stage after it hold a transaction
   // and the output register is blocked, so bubbles are squeezed out.
   always_comb begin
      logic [LANE_STAGES-1:0] mask;
      for (int k = 0; k < LANE_STAGES; k++) begin
         mask     = {LANE_STAGES{1'b1}} << k;
         ready[k] = !(((valid_ff & mask) == mask) && !out_ready);
      end
   end

   assign adv.load     = ready;
   assign adv.out_load = out_ready;
   assign req_stall    = !ready[0];
   assign rsp_valid    = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < LANE_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (out_ready) begin
            out_valid_ff <= valid_ff[LANE_STAGES-1];
         end
      end
   end

endmodule

// File: design/hbpg_lane.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hbpg_lane
// One pixel of a payload byte: coordinates, border test, block hash and
// palette index, in thirteen pipeline stages.
// -----------------------------------------------------------------------------
module hbpg_lane #(
   parameter int LANE_ID      = 0,
   parameter int IMG_WIDTH    = hbpg_pkg::DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT   = hbpg_pkg::DEF_IMG_HEIGHT,
   parameter int BLOCK_SIZE   = hbpg_pkg::DEF_BLOCK_SIZE,
   parameter int PALETTE_SIZE = hbpg_pkg::DEF_PALETTE_SIZE,
   parameter int BORDER_WIDTH = hbpg_pkg::DEF_BORDER_WIDTH
) (
   input  logic                               clock,
   input  hbpg_pkg::hbpg_adv_type             adv,
   input  logic [hbpg_pkg::BYTE_INDEX_W-1:0]  byte_index,
   input  logic [hbpg_pkg::SEED_W-1:0]        seed_mix,
   output logic [hbpg_pkg::NIBBLE_W-1:0]      nibble
);
   import hbpg_pkg::*;

   localparam int PW = PIX_W;
   localparam longint unsigned MAX_ROW = ((64'd1 << PW) - 64'd1) / IMG_WIDTH;
   localparam int COL_W = $clog2(IMG_WIDTH);
   localparam int ROW_W = $clog2(MAX_ROW + 64'd1);

   // Division by constants: floor reciprocal, one correction step later.
   localparam longint unsigned W_RECIP = (64'd1 << PW) / IMG_WIDTH;
   localparam int WR_W = $clog2(W_RECIP + 64'd1);
   localparam int M0_W = PW + WR_W;

   localparam longint unsigned BX_MAX = (IMG_WIDTH - 1) / BLOCK_SIZE;
   localparam longint unsigned BY_MAX = MAX_ROW / BLOCK_SIZE;
   localparam int BX_W = (BX_MAX > 0) ? $clog2(BX_MAX + 64'd1) : 1;
   localparam int BY_W = (BY_MAX > 0) ? $clog2(BY_MAX + 64'd1) : 1;
   localparam longint unsigned BX_RECIP = (64'd1 << COL_W) / BLOCK_SIZE;
   localparam longint unsigned BY_RECIP = (64'd1 << ROW_W) / BLOCK_SIZE;
   localparam int BXR_W = (BX_RECIP > 0) ? $clog2(BX_RECIP + 64'd1) : 1;
   localparam int BYR_W = (BY_RECIP > 0) ? $clog2(BY_RECIP + 64'd1) : 1;
   localparam int MC_W = COL_W + BXR_W;
   localparam int MR_W = ROW_W + BYR_W;
   localparam int BREM_W = $clog2(2 * BLOCK_SIZE);

   localparam logic [31:0] PAL_RECIP = 32'((64'd1 << 32) / PALETTE_SIZE);
   localparam int PAL_W = $clog2(2 * PALETTE_SIZE);

   localparam int BORDER_STAGE = 3;

   logic [PW-1:0]        pix;
   logic [M0_W-1:0]      m0_ff;
   logic [PW-1:0]        p0_ff;
   logic [ROW_W-1:0]     row_est;
   logic [ROW_W-1:0]     row1_ff;
   logic [COL_W:0]       col1_ff;
   logic [ROW_W-1:0]     row2_ff;
   logic [COL_W-1:0]     col2_ff;
   logic [MC_W-1:0]      mc3_ff;
   logic [MR_W-1:0]      mr3_ff;
   logic [COL_W-1:0]     col3_ff;
   logic [ROW_W-1:0]     row3_ff;
   logic [BX_W-1:0]      bx_est;
   logic [BY_W-1:0]      by_est;
   logic [BX_W-1:0]      bx4_ff;
   logic [BY_W-1:0]      by4_ff;
   logic [BREM_W-1:0]    remc4_ff;
   logic [BREM_W-1:0]    remr4_ff;
   logic [BX_W-1:0]      bx5_ff;
   logic [BY_W-1:0]      by5_ff;
   logic [31:0]          tx6_ff;
   logic [31:0]          ty6_ff;
   logic [31:0]          v7_ff;
   logic [31:0]          mix_a;
   logic [31:0]          m8_ff;
   logic [31:0]          mix_b;
   logic [31:0]          m9_ff;
   logic [31:0]          hash;
   logic [31:0]          h10_ff;
   logic [63:0]          hm10_ff;
   logic [31:0]          q_est;
   logic [PAL_W-1:0]     r11_ff;
   logic [NIBBLE_W-1:0]  nib12_ff;
   logic                 border_in;
   logic                 bd_ff [LANE_STAGES-2:BORDER_STAGE];

   assign pix     = {byte_index, ($clog2(LANES))'(LANE_ID)};
   assign row_est = m0_ff[PW +: ROW_W];
   assign bx_est  = mc3_ff[COL_W +: BX_W];
   assign by_est  = mr3_ff[ROW_W +: BY_W];
   assign mix_a   = v7_ff ^ (v7_ff >> FIN_S1);
   assign mix_b   = m8_ff ^ (m8_ff >> FIN_S2);
   assign hash    = m9_ff ^ (m9_ff >> FIN_S3);
   assign q_est   = hm10_ff[63:32];

   // Border tests are made on unwrapped sums, so a border wider than the
   // image marks every pixel.
   assign border_in = (32'(col2_ff) < 32'(BORDER_WIDTH)) ||
                      (32'(row2_ff) < 32'(BORDER_WIDTH)) ||
                      (32'(col2_ff) + 32'(BORDER_WIDTH) >= 32'(IMG_WIDTH)) ||
                      (32'(row2_ff) + 32'(BORDER_WIDTH) >= 32'(IMG_HEIGHT));

   always_ff @(posedge clock) begin
      if (adv.load[0]) begin
         p0_ff <= pix;
         m0_ff <= M0_W'(pix) * M0_W'(W_RECIP);
      end
      if (adv.load[1]) begin
         row1_ff <= row_est;
         col1_ff <= (COL_W+1)'(p0_ff - PW'(32'(row_est) * 32'(IMG_WIDTH)));
      end
      if (adv.load[2]) begin
         if (col1_ff >= (COL_W+1)'(IMG_WIDTH)) begin
            col2_ff <= COL_W'(col1_ff - (COL_W+1)'(IMG_WIDTH));
            row2_ff <= ROW_W'(row1_ff + 1'b1);
         end else begin
            col2_ff <= COL_W'(col1_ff);
            row2_ff <= row1_ff;
         end
      end
      if (adv.load[3]) begin
         col3_ff <= col2_ff;
         row3_ff <= row2_ff;
         mc3_ff  <= MC_W'(col2_ff) * MC_W'(BX_RECIP);
         mr3_ff  <= MR_W'(row2_ff) * MR_W'(BY_RECIP);
         bd_ff[BORDER_STAGE] <= border_in;
      end
      if (adv.load[4]) begin
         bx4_ff   <= bx_est;
         by4_ff   <= by_est;
         remc4_ff <= BREM_W'(col3_ff - COL_W'(32'(bx_est) * 32'(BLOCK_SIZE)));
         remr4_ff <= BREM_W'(row3_ff - ROW_W'(32'(by_est) * 32'(BLOCK_SIZE)));
      end
      if (adv.load[5]) begin
         bx5_ff <= (remc4_ff >= BREM_W'(BLOCK_SIZE)) ? BX_W'(bx4_ff + 1'b1) : bx4_ff;
         by5_ff <= (remr4_ff >= BREM_W'(BLOCK_SIZE)) ? BY_W'(by4_ff + 1'b1) : by4_ff;
      end
      if (adv.load[6]) begin
         tx6_ff <= 32'(32'(bx5_ff) * HASH_BX);
         ty6_ff <= 32'(32'(by5_ff) * HASH_BY);
      end
      if (adv.load[7]) begin
         v7_ff <= seed_mix + tx6_ff + ty6_ff;
      end
      if (adv.load[8]) begin
         m8_ff <= mix_a * FIN_M1;
      end
      if (adv.load[9]) begin
         m9_ff <= mix_b * FIN_M2;
      end
      if (adv.load[10]) begin
         h10_ff  <= hash;
         hm10_ff <= 64'(hash) * 64'(PAL_RECIP);
      end
      if (adv.load[11]) begin
         r11_ff <= PAL_W'(h10_ff - 32'(q_est * 32'(PALETTE_SIZE)));
      end
      if (adv.load[12]) begin
         if (bd_ff[LANE_STAGES-2]) begin
            nib12_ff <= '0;
         end else if (r11_ff >= PAL_W'(PALETTE_SIZE)) begin
            nib12_ff <= NIBBLE_W'(r11_ff - PAL_W'(PALETTE_SIZE));
         end else begin
            nib12_ff <= NIBBLE_W'(r11_ff);
         end
      end
      for (int k = BORDER_STAGE + 1; k < LANE_STAGES - 1; k++) begin
         if (adv.load[k]) begin
            bd_ff[k] <= bd_ff[k-1];
         end
      end
   end

   assign nibble = nib12_ff;

endmodule

// File: design/hashed_block_pattern_generator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hashed_block_pattern_generator
// Block test pattern for a 4-bit-per-pixel panel: each payload byte index
// yields two palette indices from a seeded spatial hash of 40-pixel blocks.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   req_byte_index [17:0]
//   rsp      out        rsp_valid / rsp_stall   rsp_payload_byte [7:0]
//   csr      in         csr_write_en            csr_write_data [31:0]
//
// One transaction per cycle is sustained while rsp_stall stays low; two pixel lanes run side by side.
// From acceptance to rsp_valid a transaction passes 13 lane stages, set by
// the reciprocal divisions and the hash multipliers, plus the output register.
// Reset clears the pipeline and sets the seed to 1.
// Input stalls only when every stage and the output register are occupied and rsp_stall is high.
// -----------------------------------------------------------------------------
module hashed_block_pattern_generator #(
   parameter int IMG_WIDTH    = hbpg_pkg::DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT   = hbpg_pkg::DEF_IMG_HEIGHT,
   parameter int BLOCK_SIZE   = hbpg_pkg::DEF_BLOCK_SIZE,
   parameter int PALETTE_SIZE = hbpg_pkg::DEF_PALETTE_SIZE,
   parameter int BORDER_WIDTH = hbpg_pkg::DEF_BORDER_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hbpg_pkg::BYTE_INDEX_W-1:0]  req_byte_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hbpg_pkg::PAYLOAD_W-1:0]     rsp_payload_byte,
   input  logic                               csr_write_en,
   input  logic [hbpg_pkg::SEED_W-1:0]        csr_write_data
);
   import hbpg_pkg::*;

   hbpg_adv_type            adv;
   logic [SEED_W-1:0]       seed_ff;
   logic [SEED_W-1:0]       seed_mix_ff;
   logic [NIBBLE_W-1:0]     nibble [LANES];
   logic [PAYLOAD_W-1:0]    payload_ff;

   hbpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .adv       (adv)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      hbpg_lane #(
         .LANE_ID      (g),
         .IMG_WIDTH    (IMG_WIDTH),
         .IMG_HEIGHT   (IMG_HEIGHT),
         .BLOCK_SIZE   (BLOCK_SIZE),
         .PALETTE_SIZE (PALETTE_SIZE),
         .BORDER_WIDTH (BORDER_WIDTH)
      ) u_lane (
         .clock      (clock),
         .adv        (adv),
         .byte_index (req_byte_index),
         .seed_mix   (seed_mix_ff),
         .nibble     (nibble[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_write_en) begin
         seed_ff <= csr_write_data;
      end
   end

   // The seed term is the same for every pixel, so it is formed once here.
   always_ff @(posedge clock) begin
      seed_mix_ff <= seed_ff * HASH_SEED;
      if (adv.out_load) begin
         payload_ff <= {nibble[0], nibble[1]};
      end
   end

   assign rsp_payload_byte = payload_ff;

endmodule

// File: design/hbpg_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hbpg_checker
// Port-level checks of the hashed block pattern generator, bound to the top.
// -----------------------------------------------------------------------------
module hbpg_checker #(
   parameter int PALETTE_SIZE = hbpg_pkg::DEF_PALETTE_SIZE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [hbpg_pkg::BYTE_INDEX_W-1:0]  req_byte_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [hbpg_pkg::PAYLOAD_W-1:0]     rsp_payload_byte,
   input  logic                               csr_write_en,
   input  logic [hbpg_pkg::SEED_W-1:0]        csr_write_data
);
   import hbpg_pkg::*;

   logic [SEED_W+BYTE_INDEX_W+1:0] unused_bits;
   assign unused_bits = {req_valid, csr_write_en, req_byte_index, csr_write_data};

   // No result may survive a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // The input is held off only when the whole pipeline is backed up.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output is free");

   // Both palette indices stay inside the palette.
   a_palette_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((32'(rsp_payload_byte[7:4]) < 32'(PALETTE_SIZE)) &&
                     (32'(rsp_payload_byte[3:0]) < 32'(PALETTE_SIZE))))
      else $error("palette index out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload_byte)))
      else $error("stalled result changed or dropped");

endmodule

bind hashed_block_pattern_generator hbpg_checker u_hbpg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_byte_index   (req_byte_index),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_byte (rsp_payload_byte),
   .csr_write_en     (csr_write_en),
   .csr_write_data   (csr_write_data)
);

// File: tb/sv/tb_hashed_block_pattern_generator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_hashed_block_pattern_generator
// Self-checking bench for the hashed block pattern generator. Byte indexes are
// sent through the req channel, and each accepted one is turned into an
// expected payload byte by a local model of the border test and the seeded
// block hash. Each rsp transaction is compared with the oldest expected byte.
// The seed register is rewritten between phases while the pipeline is empty,
// and both channels are throttled at random in different proportions.
// -----------------------------------------------------------------------------
module tb_hashed_block_pattern_generator;
   import hbpg_pkg::*;

   localparam logic [31:0] PANEL_W  = DEF_IMG_WIDTH;
   localparam logic [31:0] PANEL_H  = DEF_IMG_HEIGHT;
   localparam logic [31:0] TILE     = DEF_BLOCK_SIZE;
   localparam logic [31:0] COLORS   = DEF_PALETTE_SIZE;
   localparam logic [31:0] FRAME    = DEF_BORDER_WIDTH;
   localparam int          LATENCY  = 14;
   localparam int          DRAIN_MAX = 4000;
   localparam int          LAST_BYTE = 191999;
   localparam int          INDEX_MAX = (1 << BYTE_INDEX_W) - 1;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic [BYTE_INDEX_W-1:0] req_byte_index   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic [PAYLOAD_W-1:0]    rsp_payload_byte;
   logic                    csr_write_en     = 1'b0;
   logic [SEED_W-1:0]       csr_write_data   = '0;

   logic [SEED_W-1:0]       seed_model = SEED_RESET;
   logic [PAYLOAD_W-1:0]    payload_q[$];
   int                      mismatch_count = 0;
   int                      sender_idle_pct = 0;
   int                      receiver_idle_pct = 0;

   hashed_block_pattern_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_index   (req_byte_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Palette index of one pixel; pixels past the last row fall in the border.
   function automatic logic [NIBBLE_W-1:0] pixel_color(input logic [31:0] pix,
                                                       input logic [31:0] seed);
      logic [31:0] col;
      logic [31:0] row;
      logic [31:0] h;
      col = pix % PANEL_W;
      row = pix / PANEL_W;
      if (col < FRAME || row < FRAME || col + FRAME >= PANEL_W || row + FRAME >= PANEL_H)
         return '0;
      h = seed * HASH_SEED + (col / TILE) * HASH_BX + (row / TILE) * HASH_BY;
      h = h ^ (h >> FIN_S1);
      h = h * FIN_M1;
      h = h ^ (h >> FIN_S2);
      h = h * FIN_M2;
      h = h ^ (h >> FIN_S3);
      return NIBBLE_W'(h % COLORS);
   endfunction

   function automatic logic [PAYLOAD_W-1:0] payload_for(input logic [BYTE_INDEX_W-1:0] idx,
                                                        input logic [31:0] seed);
      logic [31:0] pix;
      pix = 32'(idx) * 2;
      return {pixel_color(pix, seed), pixel_color(pix + 1, seed)};
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (payload_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected payload byte %02h at %0t", rsp_payload_byte, $time);
         end else begin
            if (rsp_payload_byte !== payload_q[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("payload byte mismatch at %0t: expected %02h, got %02h",
                           $time, payload_q[0], rsp_payload_byte);
            end
            void'(payload_q.pop_front());
         end
      end
   end

   task automatic send_index(input logic [BYTE_INDEX_W-1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_index <= idx;
      do @(posedge clock); while (req_stall);
      payload_q.push_back(payload_for(idx, seed_model));
   endtask

   // Holds the sender off until every expected byte is back, then lets the
   // pipeline settle so that a seed write cannot reach an item in flight.
   task automatic drain_pipeline;
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (payload_q.size() != 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      if (payload_q.size() != 0) begin
         mismatch_count += payload_q.size();
         $display("%0d payload bytes never arrived", payload_q.size());
         payload_q.delete();
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [SEED_W-1:0] seed);
      csr_write_en   <= 1'b1;
      csr_write_data <= seed;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      seed_model      = seed;
      @(posedge clock);
   endtask

   // Corners and edges of the border, block boundaries, the last byte of the
   // frame, bytes past the frame and the extremes of the index field.
   task automatic send_corner_indices;
      int corners[20];
      corners = '{0, 1, 399, 1601, 1602, 1997, 1998, 1999, 4019, 4020,
                  15650, 16050, 190050, 190450, LAST_BYTE, LAST_BYTE + 1,
                  131071, 131072, INDEX_MAX - 1, INDEX_MAX};
      foreach (corners[k])
         send_index(BYTE_INDEX_W'(corners[k]));
      drain_pipeline();
   endtask

   task automatic test_reset_seed;
      send_corner_indices();
   endtask

   task automatic test_seed_extremes;
      write_seed(32'h0000_0000);
      send_corner_indices();
      write_seed(32'hffff_ffff);
      send_corner_indices();
   endtask

   // Mostly bytes inside the frame so the hash is exercised; the rest cover the
   // whole index field, including bytes past the bottom of the frame.
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      logic [BYTE_INDEX_W-1:0] idx;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      write_seed($urandom);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7)
            idx = BYTE_INDEX_W'($urandom_range(LAST_BYTE));
         else
            idx = BYTE_INDEX_W'($urandom_range(INDEX_MAX));
         send_index(idx);
      end
      drain_pipeline();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct   = 11;
      receiver_idle_pct = 70;
      test_reset_seed();
      test_seed_extremes();
      test_random_traffic(11, 70, 200);
      test_random_traffic(70, 11, 200);
      test_random_traffic(0, 0, 200);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
